// ===== rtl/core/am824_stream_depacketizer_macros.svh =====
`ifndef AM824_STREAM_DEPACKETIZER_MACROS_SVH
`define AM824_STREAM_DEPACKETIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AM824_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("am824 depacketizer check failed");

// Next-cycle implication, checked out of reset.
`define AM824_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("am824 depacketizer check failed");

`endif

// ===== rtl/core/am824d_pkg.sv =====
package am824d_pkg;

    localparam int POS_AVTP    = 18;
    localparam int POS_CIP     = 42;
    localparam int POS_PAYLOAD = 50;
    localparam int CIP_HDR_BYTES = 8;

    localparam logic [15:0] VLAN_TPID  = 16'h8100;
    localparam logic [15:0] AVTP_ETYPE = 16'h22F0;
    localparam logic [7:0]  SUBTYPE_61883 = 8'h00;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic REG_CHANNELS = 1'b0;
    localparam logic REG_WIDE     = 1'b1;

    localparam int TDATA_W    = 88;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic        has_sample;
        logic        has_end;
        logic [31:0] sample;
        logic [2:0]  slot;
        logic [7:0]  seq;
        logic [31:0] ptime;
        logic        tv;
        logic        tu;
        logic [8:0]  blocks;
    } am824d_entry_t;

endpackage

// ===== rtl/core/am824d_front.sv =====
module am824d_front #(
    parameter int MAX_FRAME_BYTES = 1518,
    parameter int MAX_CHANNELS    = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [3:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   push,
    input  logic                   push_ready,
    output am824d_pkg::am824d_entry_t push_entry
);
    import am824d_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  exp_reg, exp_next;
    logic        seeded_reg, seeded_next;
    logic        good_reg, good_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [31:0] time_reg, time_next;
    logic [1:0]  flag_reg, flag_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  bs_reg, bs_next;
    logic [23:0] quad_reg, quad_next;
    logic [7:0]  slot_reg, slot_next;
    logic [3:0]  rem_reg, rem_next;
    logic [8:0]  blk_reg, blk_next;
    logic [3:0]  chan_reg;
    logic        wide_reg;

    logic [3:0]       eff_ch;
    logic [POS_W-1:0] off;
    logic [15:0]      limit;
    logic [7:0]       slot_inc;
    logic             fire;
    logic             take_sample;
    logic             take_end;
    logic [31:0]      sample_val;

    assign eff_ch   = (32'(chan_reg) > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : chan_reg;
    assign in_ready = push_ready;
    assign fire     = in_valid & in_ready;
    assign off      = pos_reg - POS_W'(POS_PAYLOAD);
    assign slot_inc = slot_reg + 8'd1;

    always_comb
    begin
        exp_next    = exp_reg;
        seeded_next = seeded_reg;
        good_next   = good_reg;
        hdr_next    = hdr_reg;
        time_next   = time_reg;
        flag_next   = flag_reg;
        len_next    = len_reg;
        bs_next     = bs_reg;
        quad_next   = quad_reg;
        slot_next   = slot_reg;
        rem_next    = rem_reg;
        blk_next    = blk_reg;
        take_sample = 1'b0;
        limit       = (len_reg >= 16'(CIP_HDR_BYTES)) ? len_reg - 16'(CIP_HDR_BYTES) : 16'd0;
        if (32'(pos_reg) < MAX_FRAME_BYTES)
        begin
            if (pos_reg == '0)
            begin
                good_next = 1'b1;
                hdr_next  = '0;
                time_next = '0;
                flag_next = '0;
                len_next  = '0;
                bs_next   = '0;
                quad_next = '0;
                slot_next = '0;
                rem_next  = '0;
                blk_next  = '0;
            end
            hdr_next = {hdr_next[7:0], in_byte};
            priority if (pos_reg == POS_W'(13))
            begin
                if (hdr_next != VLAN_TPID)
                    good_next = 1'b0;
            end
            else if (pos_reg == POS_W'(17))
            begin
                if (hdr_next != AVTP_ETYPE)
                    good_next = 1'b0;
            end
            else if (pos_reg == POS_W'(POS_AVTP))
            begin
                if (in_byte != SUBTYPE_61883)
                    good_next = 1'b0;
            end
            else if (pos_reg == POS_W'(POS_AVTP + 1))
                flag_next[0] = in_byte[0];
            else if (pos_reg == POS_W'(POS_AVTP + 2))
            begin
                if (good_reg)
                begin
                    if (seeded_reg && in_byte != exp_reg)
                        good_next = 1'b0;
                    seeded_next = 1'b1;
                    exp_next    = in_byte + 8'd1;
                end
            end
            else if (pos_reg == POS_W'(POS_AVTP + 3))
                flag_next[1] = in_byte[0];
            else if (pos_reg >= POS_W'(30) && pos_reg <= POS_W'(33))
                time_next = {time_reg[23:0], in_byte};
            else if (pos_reg == POS_W'(39))
                len_next = hdr_next;
            else if (pos_reg == POS_W'(POS_CIP + 1))
            begin
                bs_next = in_byte;
                if (in_byte == 8'd0)
                    good_next = 1'b0;
            end
            else if (pos_reg >= POS_W'(POS_PAYLOAD) && good_reg)
            begin
                if (off[1:0] != 2'd0)
                    quad_next = {quad_reg[15:0], in_byte};
                if (off[1:0] == 2'd3
                    && (17'(off) + 17'd1) <= {1'b0, limit} && bs_reg != 8'd0)
                begin
                    if (slot_reg < {4'd0, eff_ch})
                    begin
                        take_sample = 1'b1;
                        // block count follows the kept-sample tally divided by channels
                        if (rem_reg + 4'd1 == eff_ch)
                        begin
                            rem_next = '0;
                            blk_next = blk_reg + 9'd1;
                        end
                        else
                            rem_next = rem_reg + 4'd1;
                    end
                    slot_next = (slot_inc >= bs_reg) ? 8'd0 : slot_inc;
                end
            end
            else
            begin
            end
        end
        take_end = in_last && good_next && pos_reg >= POS_W'(POS_AVTP + 2);
        if (in_last)
        begin
            pos_next  = '0;
            good_next = 1'b0;
        end
        else if (32'(pos_reg) < MAX_FRAME_BYTES)
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    assign sample_val = wide_reg ? {quad_next, 8'h00}
                                 : {{16{quad_next[23]}}, quad_next[23:8]};

    always_comb
    begin
        push_entry.has_sample = take_sample;
        push_entry.has_end    = take_end;
        push_entry.sample     = sample_val;
        push_entry.slot       = slot_reg[2:0];
        push_entry.seq        = exp_next - 8'd1;
        push_entry.ptime      = time_next;
        push_entry.tv         = flag_next[0];
        push_entry.tu         = flag_next[1];
        push_entry.blocks     = blk_next;
    end

    assign push = fire & (take_sample | take_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= 4'd2;
            wide_reg   <= 1'b1;
            pos_reg    <= '0;
            exp_reg    <= '0;
            seeded_reg <= 1'b0;
            good_reg   <= 1'b0;
            hdr_reg    <= '0;
            time_reg   <= '0;
            flag_reg   <= '0;
            len_reg    <= '0;
            bs_reg     <= '0;
            quad_reg   <= '0;
            slot_reg   <= '0;
            rem_reg    <= '0;
            blk_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHANNELS: chan_reg <= cfg_data;
                    REG_WIDE:     wide_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
            if (fire)
            begin
                pos_reg    <= pos_next;
                exp_reg    <= exp_next;
                seeded_reg <= seeded_next;
                good_reg   <= good_next;
                hdr_reg    <= hdr_next;
                time_reg   <= time_next;
                flag_reg   <= flag_next;
                len_reg    <= len_next;
                bs_reg     <= bs_next;
                quad_reg   <= quad_next;
                slot_reg   <= slot_next;
                rem_reg    <= rem_next;
                blk_reg    <= blk_next;
            end
        end
    end
endmodule

// ===== rtl/core/am824d_fifo.sv =====
module am824d_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  am824d_pkg::am824d_entry_t push_entry,
    output logic                      push_ready,
    input  logic                      pop,
    output logic                      head_valid,
    output am824d_pkg::am824d_entry_t head_entry
);
    import am824d_pkg::*;

    am824d_entry_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         wr_reg;
    logic [FIFO_AW-1:0]         rd_reg;
    logic [FIFO_AW:0]           cnt_reg;

    assign push_ready = cnt_reg != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_entry = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + FIFO_AW'(1);
            if (pop)
                rd_reg <= rd_reg + FIFO_AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (FIFO_AW + 1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (FIFO_AW + 1)'(1);
        end
    end
endmodule

// ===== rtl/core/am824d_back.sv =====
module am824d_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  am824d_pkg::am824d_entry_t head_entry,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_kind,
    output logic                      out_last,
    output logic [am824d_pkg::TDATA_W-1:0] out_data
);
    import am824d_pkg::*;

    logic                 valid_reg;
    logic                 phase_reg;
    logic                 kind_reg;
    logic                 last_reg;
    logic [TDATA_W-1:0]   data_reg;
    logic                 adv;
    logic                 split;

    assign adv   = !valid_reg | out_ready;
    // an entry holding both a sample and a frame end goes out as two beats
    assign split = head_entry.has_sample & head_entry.has_end & !phase_reg;
    assign pop   = adv & head_valid & !split;

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            kind_reg  <= KIND_SAMPLE;
            last_reg  <= 1'b0;
            data_reg  <= '0;
        end
        else if (adv)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                if (head_entry.has_sample && !phase_reg)
                begin
                    kind_reg  <= KIND_SAMPLE;
                    last_reg  <= !split;
                    phase_reg <= split;
                    data_reg  <= {1'b0, 1'b0, 9'd0, head_entry.tu, head_entry.tv,
                                  head_entry.ptime, head_entry.seq, head_entry.slot,
                                  head_entry.sample};
                end
                else
                begin
                    kind_reg  <= KIND_END;
                    last_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    data_reg  <= {1'b0, head_entry.blocks != 9'd0, head_entry.blocks,
                                  head_entry.tu, head_entry.tv, head_entry.ptime,
                                  head_entry.seq, 3'd0, 32'd0};
                end
            end
        end
    end
endmodule

// ===== rtl/core/am824_stream_depacketizer.sv =====
// channel   | dir | width            | contents
// s_axis    | in  | tdata 8, tlast   | frame bytes, tlast on final byte
// m_axis    | out | tdata 88, tuser 1| sample or frame-end records, tlast on last of a byte
// cfg       | in  | index 1, data 4  | channels_in_use, wide_samples
// One byte is taken per cycle while s_tready is high; front-end header parsing and
// sample extraction are registered per byte. A byte yielding a sample and a frame end
// needs two output beats; the output runs at one record per cycle while m_tready is high.
// A four-entry queue separates parsing from output; s_tready drops only when it fills.
// Reset clears all parse state and the queue; no clearing pass.
`include "am824_stream_depacketizer_macros.svh"

module am824_stream_depacketizer #(
    parameter int MAX_FRAME_BYTES = 1518,
    parameter int MAX_CHANNELS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] pcm_sample, [34:32] channel_slot, [42:35] sequence_value,
    // [74:43] presentation_time, [75] time_valid, [76] ts_uncertain,
    // [85:77] block_count, [86] queued, [87] zero
    output logic [am824d_pkg::TDATA_W-1:0] m_tdata,
    output logic        m_tuser,   // [0] record_kind
    output logic        m_tlast
);
    import am824d_pkg::*;

    logic          push;
    logic          push_ready;
    am824d_entry_t push_entry;
    logic          pop;
    logic          head_valid;
    am824d_entry_t head_entry;

    am824d_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_CHANNELS    (MAX_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    am824d_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    am824d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_last   (m_tlast),
        .out_data   (m_tdata)
    );

    `AM824_ASSERT_NOW(a_no_overflow, push, push_ready)
    `AM824_ASSERT_NOW(a_no_underflow, pop, head_valid)
    `AM824_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser == KIND_END, m_tlast)
    `AM824_ASSERT_NOW(a_sample_no_count, m_tvalid && m_tuser == KIND_SAMPLE, m_tdata[86:77] == 10'd0)
    `AM824_ASSERT_NEXT(a_split_holds, m_tvalid && !m_tlast && m_tready, m_tvalid && m_tuser == KIND_END)

endmodule
